### src/sha1de_pkg.sv
// Shared types and constants for the SHA-1 digest engine.
// Holds the request and response item structs, the initial vector and round constants.
// No dependencies.
`default_nettype none

package sha1de_pkg;

   localparam int DIGEST_WORDS = 5;
   localparam int BLOCK_WORDS  = 16;
   localparam int ROUNDS       = 80;

   localparam logic [31:0] IV_WORDS [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [2:0] LAST_INDEX = 3'd4;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_valid;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

endpackage

`default_nettype wire

### src/sha1_digest_engine_unit.sv
// Top level of the SHA-1 digest engine: byte packing, padding, 80-round compression.
// Depends on sha1de_pkg for item types and constants.
// Message bytes are accepted one per cycle while the engine is idle and are packed into a
// 16-word block memory. Every 64th byte starts a compression (one read prefetch, 80 rounds
// at one round per cycle through a single round datapath fed from the schedule memories,
// one chaining add) during which no byte is taken. An item marked last then costs padding
// writes and one or two compressions. The five digest words leave from an output buffer,
// so the next message can load while they drain.
`default_nettype none

module sha1_digest_engine_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire sha1de_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output sha1de_pkg::rsp_type  rsp_data
);
   import sha1de_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MARK = 3'd1;
   localparam logic [2:0] S_PAD  = 3'd2;
   localparam logic [2:0] S_PRE  = 3'd3;
   localparam logic [2:0] S_RND  = 3'd4;
   localparam logic [2:0] S_ADD  = 3'd5;

   localparam logic [1:0] AFT_IDLE = 2'd0;
   localparam logic [1:0] AFT_MARK = 2'd1;
   localparam logic [1:0] AFT_PAD  = 2'd2;
   localparam logic [1:0] AFT_EMIT = 2'd3;

   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

   logic [2:0]  state_ff, state_in;
   logic [1:0]  after_ff, after_in;
   logic [60:0] cnt_ff, cnt_in;
   logic [31:0] word_ff, word_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [3:0]  pw_ff, pw_in;
   logic        extra_ff, extra_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] h1_ff, h2_ff, h3_ff;
   logic [31:0] chain_ff [DIGEST_WORDS];
   logic [31:0] obuf_ff [DIGEST_WORDS];
   logic [2:0]  oidx_ff;
   logic        obusy_ff;

   logic [31:0] wmem_a_ff [BLOCK_WORDS];
   logic [31:0] wmem_b_ff [BLOCK_WORDS];
   logic [31:0] rda0_ff, rda1_ff, rdb_ff;

   logic        we;
   logic [3:0]  waddr;
   logic [31:0] wdata;
   logic [3:0]  next_t, ra0, ra1, rb;

   logic        req_fire, rsp_fire;
   logic [5:0]  pos;
   logic [31:0] byte_bits, byte_word, mark_bits, mark_word;
   logic [31:0] w_sched, w_cur, f_val, k_val, tmp;
   logic [31:0] sums [DIGEST_WORDS];
   logic        load_out;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = obusy_ff;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign rsp_data.digest_word = obuf_ff[0];
   assign rsp_data.word_index  = oidx_ff;
   assign rsp_data.last_word   = (oidx_ff == LAST_INDEX);

   assign pos       = cnt_ff[5:0];
   assign byte_bits = {req_data.msg_byte, 24'd0} >> {pos[1:0], 3'd0};
   assign byte_word = (pos[1:0] == 2'd0) ? byte_bits : (word_ff | byte_bits);
   assign mark_bits = {PAD_BYTE, 24'd0} >> {pos[1:0], 3'd0};
   assign mark_word = (pos[1:0] == 2'd0) ? mark_bits : (word_ff | mark_bits);

   assign w_sched = {(h3_ff[30:0] ^ rda0_ff[30:0] ^ rda1_ff[30:0] ^ rdb_ff[30:0]),
                     (h3_ff[31] ^ rda0_ff[31] ^ rda1_ff[31] ^ rdb_ff[31])};
   assign w_cur   = (rnd_ff < 7'd16) ? rdb_ff : w_sched;

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_ROUND0;
      end else if (rnd_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND1;
      end else if (rnd_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_ROUND2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND3;
      end
   end

   assign tmp = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;

   assign sums[0] = chain_ff[0] + a_ff;
   assign sums[1] = chain_ff[1] + b_ff;
   assign sums[2] = chain_ff[2] + c_ff;
   assign sums[3] = chain_ff[3] + d_ff;
   assign sums[4] = chain_ff[4] + e_ff;

   assign next_t = (state_ff == S_RND) ? (rnd_ff[3:0] + 4'd1) : 4'd0;
   assign ra0    = next_t + 4'd8;
   assign ra1    = next_t + 4'd2;
   assign rb     = next_t;

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      cnt_in   = cnt_ff;
      word_in  = word_ff;
      rnd_in   = rnd_ff;
      pw_in    = pw_ff;
      extra_in = extra_ff;
      we       = 1'b0;
      waddr    = pos[5:2];
      wdata    = byte_word;
      load_out = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.byte_valid) begin
                  word_in = byte_word;
                  cnt_in  = cnt_ff + 61'd1;
                  if (pos[1:0] == 2'd3) begin
                     we = 1'b1;
                  end
                  if (pos == 6'd63) begin
                     state_in = S_PRE;
                     after_in = req_data.last_byte ? AFT_MARK : AFT_IDLE;
                  end else if (req_data.last_byte) begin
                     state_in = S_MARK;
                  end
               end else if (req_data.last_byte) begin
                  state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            we    = 1'b1;
            wdata = mark_word;
            if (pos[5:2] == 4'd15) begin
               state_in = S_PRE;
               after_in = AFT_PAD;
            end else if (pos[5:2] == 4'd14) begin
               pw_in    = 4'd15;
               extra_in = 1'b1;
               state_in = S_PAD;
            end else begin
               pw_in    = pos[5:2] + 4'd1;
               extra_in = 1'b0;
               state_in = S_PAD;
            end
         end
         S_PAD: begin
            we    = 1'b1;
            waddr = pw_ff;
            if (!extra_ff && pw_ff == 4'd14) begin
               wdata = cnt_ff[60:29];
            end else if (!extra_ff && pw_ff == 4'd15) begin
               wdata = {cnt_ff[28:0], 3'd0};
            end else begin
               wdata = 32'd0;
            end
            if (pw_ff == 4'd15) begin
               state_in = S_PRE;
               after_in = extra_ff ? AFT_PAD : AFT_EMIT;
            end else begin
               pw_in = pw_ff + 4'd1;
            end
         end
         S_PRE: begin
            rnd_in   = 7'd0;
            state_in = S_RND;
         end
         S_RND: begin
            we    = 1'b1;
            waddr = rnd_ff[3:0];
            wdata = w_cur;
            if (rnd_ff == LAST_ROUND) begin
               state_in = S_ADD;
            end else begin
               rnd_in = rnd_ff + 7'd1;
            end
         end
         S_ADD: begin
            case (after_ff)
               AFT_EMIT: begin
                  if (!obusy_ff) begin
                     load_out = 1'b1;
                     cnt_in   = 61'd0;
                     state_in = S_IDLE;
                  end
               end
               AFT_PAD: begin
                  pw_in    = 4'd0;
                  extra_in = 1'b0;
                  state_in = S_PAD;
               end
               AFT_MARK: state_in = S_MARK;
               default:  state_in = S_IDLE;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         wmem_a_ff[waddr] <= wdata;
         wmem_b_ff[waddr] <= wdata;
      end
      rda0_ff <= wmem_a_ff[ra0];
      rda1_ff <= wmem_a_ff[ra1];
      rdb_ff  <= wmem_b_ff[rb];
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      rnd_ff   <= rnd_in;
      pw_ff    <= pw_in;
      extra_ff <= extra_in;
      if (state_ff == S_PRE) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (state_ff == S_RND) begin
         a_ff  <= tmp;
         b_ff  <= a_ff;
         c_ff  <= {b_ff[1:0], b_ff[31:2]};
         d_ff  <= c_ff;
         e_ff  <= d_ff;
         h1_ff <= w_cur;
         h2_ff <= h1_ff;
         h3_ff <= h2_ff;
      end
      if (load_out) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            obuf_ff[i] <= sums[i];
         end
      end else if (rsp_fire) begin
         for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
            obuf_ff[i] <= obuf_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         after_ff <= AFT_IDLE;
         cnt_ff   <= 61'd0;
         oidx_ff  <= 3'd0;
         obusy_ff <= 1'b0;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= IV_WORDS[i];
         end
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         cnt_ff   <= cnt_in;
         if (state_ff == S_ADD && after_ff != AFT_EMIT) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_ff[i] <= sums[i];
            end
         end else if (load_out) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_ff[i] <= IV_WORDS[i];
            end
         end
         if (load_out) begin
            obusy_ff <= 1'b1;
            oidx_ff  <= 3'd0;
         end else if (rsp_fire) begin
            oidx_ff <= oidx_ff + 3'd1;
            if (oidx_ff == LAST_INDEX) begin
               obusy_ff <= 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

### src/sha1de_checker.sv
// Port-level checker for the SHA-1 digest engine and its bind to the top level.
// Depends on sha1de_pkg and on the ports of sha1_digest_engine_unit.
`default_nettype none

module sha1de_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire sha1de_pkg::rsp_type rsp_data
);
   import sha1de_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("A stalled digest item changed or was dropped.");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == LAST_INDEX)))
      else $error("The last-word flag does not match the word index.");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
         rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("Digest words did not follow in order.");

   a_new_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_word |=>
         !rsp_valid || (rsp_data.word_index == 3'd0))
      else $error("A digest did not start at word zero.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A digest item was shown right after reset.");

endmodule

bind sha1_digest_engine_unit sha1de_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
